// ----- rtl/core/rgsl_pkg.sv -----
package rgsl_pkg;

  // input request and result payloads
  typedef struct packed {
    logic       read_present;
    logic [2:0] base;
    logic [6:0] qscore;
    logic       last_of_individual;
    logic       last_of_site;
  } in_item_t;

  typedef struct packed {
    logic [47:0] neg_loglike;
    logic        no_data;
  } out_item_t;

  // configuration register indexes
  localparam logic [1:0] CFG_ALT_FREQ = 2'd0;
  localparam logic [1:0] CFG_ADMIX    = 2'd1;
  localparam logic [1:0] CFG_MAJOR    = 2'd2;
  localparam logic [1:0] CFG_MINOR    = 2'd3;

  // fixed-point constants
  localparam logic [32:0] ONE32     = 33'h1_0000_0000;
  localparam logic [33:0] LN2_Q32   = 34'd2977044472;
  localparam logic [33:0] LOG2E_Q32 = 34'd6196328019;
  localparam logic [33:0] L2TEN_Q32 = 34'd14267572527;
  // L2TEN_Q32 = 10 * L2TEN_D10 + 7
  localparam logic [33:0] L2TEN_D10 = 34'd1426757252;
  localparam logic [39:0] MAX40     = {40{1'b1}};
  localparam logic [47:0] MAX48     = {48{1'b1}};
  localparam int          DIV_W     = 41;

  // datapath micro-operations
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE  = 5'd0;
  localparam op_t OP_LOAD  = 5'd1;
  localparam op_t OP_QMUL  = 5'd2;
  localparam op_t OP_DSTEP = 5'd3;
  localparam op_t OP_W     = 5'd5;
  localparam op_t OP_TMUL  = 5'd6;
  localparam op_t OP_TADD  = 5'd7;
  localparam op_t OP_EFIN  = 5'd8;
  localparam op_t OP_ERR   = 5'd9;
  localparam op_t OP_RP1   = 5'd10;
  localparam op_t OP_RP2   = 5'd11;
  localparam op_t OP_LINIT = 5'd12;
  localparam op_t OP_LSQ   = 5'd13;
  localparam op_t OP_LFIN  = 5'd14;
  localparam op_t OP_GACC  = 5'd15;
  localparam op_t OP_INF   = 5'd16;
  localparam op_t OP_FINIT = 5'd17;
  localparam op_t OP_FX    = 5'd18;
  localparam op_t OP_FPRI  = 5'd19;
  localparam op_t OP_FACC  = 5'd20;
  localparam op_t OP_FLN   = 5'd21;
  localparam op_t OP_FSITE = 5'd22;
  localparam op_t OP_ICLR  = 5'd23;
  localparam op_t OP_OUT   = 5'd24;

  // datapath status towards the controller
  typedef struct packed {
    logic inform;
    logic div_last;
    logic n_last;
    logic ln_last;
    logic k_last;
    logic d_big;
    logic end_any;
    logic end_site;
    logic indiv;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/core/rgsl_datapath.sv -----
module rgsl_datapath #(
  parameter int FRAC_BITS = 16,
  parameter int QUAL_MAX  = 93
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rgsl_pkg::op_t        op,
  output rgsl_pkg::dp_status_t status,
  input  rgsl_pkg::in_item_t   in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [16:0]          cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output rgsl_pkg::out_item_t  out_data
);
  import rgsl_pkg::*;

  localparam int          DW    = FRAC_BITS + 5;
  localparam int          LNW   = FRAC_BITS + 6;
  localparam logic [39:0] RND   = 40'(1) << (31 - FRAC_BITS);
  localparam logic [39:0] BIG_D = 40'(32) << FRAC_BITS;
  localparam logic [6:0]  QMAX7 = 7'(QUAL_MAX);

  logic [16:0]      alt_r, admix_r;
  logic [1:0]       major_r, minor_r;
  in_item_t         item_r;
  logic [2:0][39:0] geno_r;
  logic [47:0]      site_r;
  logic             indiv_r, any_r;
  logic [40:0]      dnum_r;
  logic [4:0]       drem_r, dden_r;
  logic [5:0]       dcnt_r;
  logic [40:0]      x_r;
  logic [30:0]      w_r;
  logic [31:0]      t_r;
  logic [33:0]      esum_r;
  logic [4:0]       n_r;
  logic [32:0]      e_r, err_r, lp_r, prior_r;
  logic [1:0]       k_r;
  logic [31:0]      lx_r, fr_r;
  logic [4:0]       le_r, lcnt_r;
  logic             lone_r;
  logic [LNW-1:0]   ln_r;
  logic [39:0]      cmin_r;
  logic [34:0]      fsum_r;
  logic [49:0]      prod_r;
  logic             out_valid_r;
  out_item_t        out_r;

  // decoded item and config
  logic [6:0]  qq;
  logic        is_major;
  logic [16:0] m_c, mc, f_c, g_c;
  logic [32:0] good, aval, bval;
  logic [39:0] d_val, cmin_c;

  always_comb begin
    qq       = (item_r.qscore > QMAX7) ? QMAX7 : item_r.qscore;
    is_major = (item_r.base == {1'b0, major_r});
    m_c      = admix_r[16] ? 17'h10000 : admix_r;
    mc       = 17'h10000 - m_c;
    f_c      = alt_r[16] ? 17'h10000 : alt_r;
    g_c      = 17'h10000 - f_c;
    good     = ONE32 - err_r;
    aval     = is_major ? good : err_r;
    case (k_r)
      2'd0:    bval = aval;
      2'd1:    bval = 33'h0_8000_0000;
      default: bval = is_major ? err_r : good;
    endcase
    d_val  = geno_r[k_r] - cmin_r;
    cmin_c = geno_r[0];
    if (geno_r[1] < cmin_c) cmin_c = geno_r[1];
    if (geno_r[2] < cmin_c) cmin_c = geno_r[2];
  end

  // shared multiplier
  logic [33:0] mul_a, mul_b;
  logic [67:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_QMUL: begin mul_a = 34'(qq); mul_b = L2TEN_D10; end
      OP_W:    begin mul_a = 34'(ONE32 - {1'b0, x_r[31:0]}); mul_b = LN2_Q32; end
      OP_TMUL: begin mul_a = 34'(t_r); mul_b = 34'(w_r); end
      OP_RP1:  begin mul_a = 34'(aval); mul_b = 34'(mc); end
      OP_RP2:  begin mul_a = 34'(bval); mul_b = 34'(m_c); end
      OP_LSQ:  begin mul_a = 34'(lx_r); mul_b = 34'(lx_r); end
      OP_FX:   begin mul_a = 34'(d_val[DW-1:0]); mul_b = LOG2E_Q32; end
      OP_FPRI: begin
        mul_a = (k_r == 2'd0) ? 34'(g_c) : 34'(f_c);
        mul_b = (k_r == 2'd2) ? 34'(f_c) : 34'(g_c);
      end
      OP_FACC: begin mul_a = 34'(e_r[32:1]); mul_b = 34'(prior_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = 68'(mul_a) * 68'(mul_b);
  end

  // (7q + 5) / 10 by reciprocal multiply, exact for the clamped range
  logic [9:0]  qrem;
  logic [17:0] qrem_m;
  logic [6:0]  qfix;
  always_comb begin
    qrem   = 10'(qq) * 10'd7 + 10'd5;
    qrem_m = 18'(qrem) * 18'd205;
    qfix   = qrem_m[17:11];
  end

  // serial divider step
  logic [5:0] rsh;
  logic       dge;
  always_comb begin
    rsh = {drem_r, dnum_r[40]};
    dge = (rsh >= {1'b0, dden_r});
  end

  // read probability sum
  logic [49:0] rp_sum;
  logic [32:0] rp_p;
  always_comb begin
    rp_sum = prod_r + mul_p[49:0];
    rp_p   = rp_sum[48:16];
    if (rp_p == '0) rp_p = 33'd1;
    if (rp_p > ONE32) rp_p = ONE32;
  end

  // log normalisation and finish
  logic [31:0] p32;
  logic [4:0]  lead;
  logic [32:0] sq;
  logic [37:0] lm;
  logic [39:0] mag;
  always_comb begin
    p32  = (lp_r[31:0] == '0) ? 32'd1 : lp_r[31:0];
    lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (p32[i]) lead = 5'(i);
    end
    sq  = mul_p[63:31];
    lm  = {6'(6'd32 - {1'b0, le_r}), 32'b0} - {6'b0, fr_r};
    mag = 40'(lm[37:32]) * 40'(LN2_Q32)
        + 40'((64'(lm[31:0]) * 64'(LN2_Q32)) >> 32);
  end

  // exp2 final shift
  logic [8:0]  ip;
  logic [34:0] eshift;
  always_comb begin
    ip     = x_r[40:32];
    eshift = {1'b0, esum_r} << 1;
    eshift = eshift >> (7'(ip[5:0]) + 7'd1);
  end

  // accumulator sums
  logic [40:0] gsum;
  logic [49:0] ssum;
  logic [32:0] fclamp;
  always_comb begin
    gsum   = {1'b0, geno_r[k_r]} + 41'(ln_r);
    ssum   = 50'(site_r) + 50'(cmin_r) + 50'(ln_r);
    fclamp = (fsum_r == '0) ? 33'd1 : (fsum_r > 35'(ONE32)) ? ONE32 : fsum_r[32:0];
  end

  // control state: config, flags, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alt_r       <= '0;
      admix_r     <= 17'h10000;
      major_r     <= 2'd0;
      minor_r     <= 2'd1;
      indiv_r     <= 1'b0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ALT_FREQ: alt_r   <= cfg_data;
          CFG_ADMIX:    admix_r <= cfg_data;
          CFG_MAJOR:    major_r <= cfg_data[1:0];
          CFG_MINOR:    minor_r <= cfg_data[1:0];
          default:      ;
        endcase
      end
      out_valid_r <= (op == OP_OUT) || (out_valid_r && out_stall);
      case (op)
        OP_INF:  begin indiv_r <= 1'b1; any_r <= 1'b1; end
        OP_ICLR: indiv_r <= 1'b0;
        OP_OUT:  any_r <= 1'b0;
        default: ;
      endcase
    end
  end

  // accumulators (reset to zero)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geno_r <= '0;
      site_r <= '0;
    end else begin
      case (op)
        OP_GACC:  geno_r[k_r] <= gsum[40] ? MAX40 : gsum[39:0];
        OP_FSITE: site_r <= (ssum > 50'(MAX48)) ? MAX48 : ssum[47:0];
        OP_ICLR:  geno_r <= '0;
        OP_OUT:   site_r <= '0;
        default:  ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: item_r <= in_data;
      OP_QMUL: x_r <= 41'(mul_p) + 41'(qfix);
      OP_DSTEP: begin
        drem_r <= dge ? 5'(rsh - {1'b0, dden_r}) : rsh[4:0];
        dnum_r <= {dnum_r[39:0], dge};
        dcnt_r <= dcnt_r - 6'd1;
      end
      OP_W: begin
        w_r    <= 31'(mul_p >> 33);
        t_r    <= 32'h8000_0000;
        esum_r <= 34'h8000_0000;
        n_r    <= 5'd1;
      end
      OP_TMUL: begin
        dnum_r <= 41'(mul_p >> 31);
        dden_r <= n_r;
        drem_r <= '0;
        dcnt_r <= 6'(DIV_W);
      end
      OP_TADD: begin
        t_r    <= dnum_r[31:0];
        esum_r <= esum_r + 34'(dnum_r);
        n_r    <= n_r + 5'd1;
      end
      OP_EFIN: e_r <= (ip > 9'd62) ? '0 : eshift[32:0];
      OP_ERR: begin
        err_r <= (e_r > ONE32) ? ONE32 : e_r;
        k_r   <= '0;
      end
      OP_RP1: prod_r <= mul_p[49:0];
      OP_RP2: lp_r <= rp_p;
      OP_LINIT: begin
        lone_r <= lp_r[32];
        lx_r   <= p32 << (5'd31 - lead);
        le_r   <= lead;
        fr_r   <= '0;
        lcnt_r <= 5'd31;
      end
      OP_LSQ: begin
        lx_r   <= sq[32] ? sq[32:1] : sq[31:0];
        if (sq[32]) fr_r[lcnt_r] <= 1'b1;
        lcnt_r <= lcnt_r - 5'd1;
      end
      OP_LFIN: ln_r <= lone_r ? '0 : LNW'((mag + RND) >> (32 - FRAC_BITS));
      OP_GACC: k_r <= k_r + 2'd1;
      OP_FINIT: begin
        cmin_r <= cmin_c;
        k_r    <= '0;
        fsum_r <= '0;
      end
      OP_FX: begin
        x_r <= 41'(mul_p >> FRAC_BITS);
        if (d_val >= BIG_D) e_r <= '0;
      end
      OP_FPRI: prior_r <= (k_r == 2'd1) ? 33'(mul_p << 1) : 33'(mul_p);
      OP_FACC: begin
        fsum_r <= fsum_r + 35'(mul_p >> 31);
        k_r    <= k_r + 2'd1;
      end
      OP_FLN: lp_r <= fclamp;
      OP_OUT: out_r <= '{neg_loglike: site_r, no_data: !any_r};
      default: ;
    endcase
  end

  // status
  always_comb begin
    status.inform   = item_r.read_present && !item_r.base[2] &&
                      (item_r.base[1:0] == major_r || item_r.base[1:0] == minor_r);
    status.div_last = (dcnt_r == 6'd1);
    status.n_last   = (n_r == 5'd16);
    status.ln_last  = (lcnt_r == 5'd0);
    status.k_last   = (k_r == 2'd2);
    status.d_big    = (d_val >= BIG_D);
    status.end_any  = item_r.last_of_individual || item_r.last_of_site;
    status.end_site = item_r.last_of_site;
    status.indiv    = indiv_r;
    status.out_busy = out_valid_r && out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/rgsl_ctrl.sv -----
module rgsl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rgsl_pkg::dp_status_t status,
  output rgsl_pkg::op_t        op
);
  import rgsl_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DEC   = 5'd1;
  localparam logic [4:0] S_W     = 5'd4;
  localparam logic [4:0] S_TMUL  = 5'd5;
  localparam logic [4:0] S_TDIV  = 5'd6;
  localparam logic [4:0] S_TADD  = 5'd7;
  localparam logic [4:0] S_EFIN  = 5'd8;
  localparam logic [4:0] S_ERR   = 5'd9;
  localparam logic [4:0] S_RP1   = 5'd10;
  localparam logic [4:0] S_RP2   = 5'd11;
  localparam logic [4:0] S_LINIT = 5'd12;
  localparam logic [4:0] S_LSQ   = 5'd13;
  localparam logic [4:0] S_LFIN  = 5'd14;
  localparam logic [4:0] S_GACC  = 5'd15;
  localparam logic [4:0] S_INF   = 5'd16;
  localparam logic [4:0] S_END   = 5'd17;
  localparam logic [4:0] S_FINIT = 5'd18;
  localparam logic [4:0] S_FX    = 5'd19;
  localparam logic [4:0] S_FPRI  = 5'd20;
  localparam logic [4:0] S_FACC  = 5'd21;
  localparam logic [4:0] S_FLN   = 5'd22;
  localparam logic [4:0] S_FSITE = 5'd23;
  localparam logic [4:0] S_ICLR  = 5'd24;
  localparam logic [4:0] S_OUT   = 5'd25;

  logic [4:0] state_r, state_nxt;
  logic       fold_r, fold_nxt;

  assign in_stall = (state_r != S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    fold_nxt  = fold_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (status.inform) begin
          op        = OP_QMUL;
          state_nxt = S_W;
        end else begin
          state_nxt = S_END;
        end
      end
      S_W: begin
        op        = OP_W;
        state_nxt = S_TMUL;
      end
      S_TMUL: begin
        op        = OP_TMUL;
        state_nxt = S_TDIV;
      end
      S_TDIV: begin
        op = OP_DSTEP;
        if (status.div_last) state_nxt = S_TADD;
      end
      S_TADD: begin
        op        = OP_TADD;
        state_nxt = status.n_last ? S_EFIN : S_TMUL;
      end
      S_EFIN: begin
        op        = OP_EFIN;
        state_nxt = fold_r ? S_FPRI : S_ERR;
      end
      S_ERR: begin
        op        = OP_ERR;
        state_nxt = S_RP1;
      end
      S_RP1: begin
        op        = OP_RP1;
        state_nxt = S_RP2;
      end
      S_RP2: begin
        op        = OP_RP2;
        state_nxt = S_LINIT;
      end
      S_LINIT: begin
        op        = OP_LINIT;
        state_nxt = S_LSQ;
      end
      S_LSQ: begin
        op = OP_LSQ;
        if (status.ln_last) state_nxt = S_LFIN;
      end
      S_LFIN: begin
        op        = OP_LFIN;
        state_nxt = fold_r ? S_FSITE : S_GACC;
      end
      S_GACC: begin
        op        = OP_GACC;
        state_nxt = status.k_last ? S_INF : S_RP1;
      end
      S_INF: begin
        op        = OP_INF;
        state_nxt = S_END;
      end
      S_END: begin
        if (!status.end_any) state_nxt = S_IDLE;
        else if (status.indiv) state_nxt = S_FINIT;
        else state_nxt = S_ICLR;
      end
      S_FINIT: begin
        op        = OP_FINIT;
        fold_nxt  = 1'b1;
        state_nxt = S_FX;
      end
      S_FX: begin
        op        = OP_FX;
        state_nxt = status.d_big ? S_FPRI : S_W;
      end
      S_FPRI: begin
        op        = OP_FPRI;
        state_nxt = S_FACC;
      end
      S_FACC: begin
        op        = OP_FACC;
        state_nxt = status.k_last ? S_FLN : S_FX;
      end
      S_FLN: begin
        op        = OP_FLN;
        state_nxt = S_LINIT;
      end
      S_FSITE: begin
        op        = OP_FSITE;
        fold_nxt  = 1'b0;
        state_nxt = S_ICLR;
      end
      S_ICLR: begin
        op        = OP_ICLR;
        state_nxt = status.end_site ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fold_r  <= fold_nxt;
    end
  end

endmodule

// ----- rtl/core/read_genotype_site_loglike_top.sv -----
// Site genotype log likelihood. Reads arrive one request at a time, grouped by
// individual; each read matching the configured major or minor allele adds
// -ln P under three genotype cases, each individual is folded into the site
// total by a prior-weighted log-sum-exp, and the last request of a site gives
// one result (negative log likelihood, Q.FRAC_BITS, saturating at 2^48-1, and
// a no-data flag). The block handles one request at a time. An informative read
// spends nearly all its time in the 2^x Taylor evaluation, whose 16 terms each
// pass through the shared one-bit-a-cycle divider, plus three probability and
// log evaluations. Closing an individual adds three exponentials and one log.
// The result sits in an output register, so the next request is taken while
// it waits, unless an earlier result is still held there. Config writes are
// always ready and must only be made while the block is idle.
module read_genotype_site_loglike_top #(
  parameter int FRAC_BITS = 16,
  parameter int QUAL_MAX  = 93
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rgsl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rgsl_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_data
);
  import rgsl_pkg::*;

  op_t        op;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  rgsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  rgsl_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .QUAL_MAX  (QUAL_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .status    (status),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import rgsl_pkg::*;

  typedef bit [63:0] u64;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = CFG_ALT_FREQ;
  logic [16:0] cfg_data = '0;

  // predictor state and register copies
  u64  freq_q, admix_q;
  bit [1:0] major_q, minor_q;
  u64  case_nll[3];
  u64  site_nll;
  bit  indiv_hit, site_hit;

  out_item_t site_results[$];
  row_t      dir_rows[$];
  int        errors = 0;
  int        results_seen = 0;

  read_genotype_site_loglike_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // 2^a in Q32, a in (0, 1] as Q32, Taylor series of e^(a ln2)
  function automatic u64 two_pow_frac(u64 a);
    u64 w, t, acc;
    w = ((a * u64'(LN2_Q32)) >> 32) >> 1;
    t = u64'(1) << 31;
    acc = t;
    for (int n = 1; n <= 16; n++) begin
      t = ((t * w) >> 31) / u64'(n);
      acc += t;
    end
    return acc << 1;
  endfunction

  // 2^(-x) in Q0.32
  function automatic u64 two_pow_neg(u64 x);
    u64 ip;
    ip = x >> 32;
    if (ip > 62) return 0;
    return two_pow_frac((u64'(1) << 32) - (x & 64'hFFFF_FFFF)) >> (ip + 1);
  endfunction

  // exp(-d), d in Q16
  function automatic u64 exp_neg_q(u64 d);
    if (d >= (u64'(32) << 16)) return 0;
    return two_pow_neg((d * u64'(LOG2E_Q32)) >> 16);
  endfunction

  // -ln(p / 2^32) rounded to Q16
  function automatic u64 neg_ln_q(u64 p);
    int e;
    u64 x, fr, lm, li, lf, mag;
    e = 31;
    fr = 0;
    if (p == 0) p = 1;
    if (p >= (u64'(1) << 32)) return 0;
    while (e > 0 && p[e] == 1'b0) e--;
    x = p << (31 - e);
    for (int k = 31; k >= 0; k--) begin
      x = (x * x) >> 31;
      if (x >= (u64'(1) << 32)) begin
        x = x >> 1;
        fr[k] = 1'b1;
      end
    end
    lm = (u64'(32 - e) << 32) - fr;
    li = lm >> 32;
    lf = lm & 64'hFFFF_FFFF;
    mag = li * u64'(LN2_Q32) + ((lf * u64'(LN2_Q32)) >> 32);
    return (mag + (u64'(1) << 15)) >> 16;
  endfunction

  function automatic u64 phred_err(bit [6:0] q);
    u64 qq, e;
    qq = (q > 7'd93) ? u64'(93) : u64'(q);
    e = two_pow_neg((qq * u64'(L2TEN_Q32) + 5) / 10);
    return (e > (u64'(1) << 32)) ? (u64'(1) << 32) : e;
  endfunction

  function automatic u64 read_lik(bit is_major, int k, u64 err);
    u64 m, a, b, p, one;
    one = u64'(1) << 32;
    m = (admix_q > 65536) ? 65536 : admix_q;
    a = is_major ? one - err : err;
    if (k == 0) b = a;
    else if (k == 1) b = one >> 1;
    else b = is_major ? err : one - err;
    p = (a * (65536 - m) + b * m) >> 16;
    if (p == 0) p = 1;
    if (p > one) p = one;
    return p;
  endfunction

  // log-sum-exp of the three cases under Hardy-Weinberg priors
  function automatic void fold_indiv();
    u64 f, g, cmin, acc, tot, e;
    u64 prior[3];
    f = (freq_q > 65536) ? 65536 : freq_q;
    g = 65536 - f;
    prior[0] = g * g;
    prior[1] = 2 * f * g;
    prior[2] = f * f;
    cmin = case_nll[0];
    acc = 0;
    for (int k = 1; k < 3; k++) if (case_nll[k] < cmin) cmin = case_nll[k];
    for (int k = 0; k < 3; k++) begin
      e = exp_neg_q(case_nll[k] - cmin);
      acc += ((e >> 1) * prior[k]) >> 31;
    end
    if (acc == 0) acc = 1;
    if (acc > (u64'(1) << 32)) acc = u64'(1) << 32;
    tot = site_nll + cmin + neg_ln_q(acc);
    site_nll = (tot > u64'(MAX48)) ? u64'(MAX48) : tot;
  endfunction

  // advance the predictor by one request; returns 1 with a site result
  function automatic bit predict_site(in_item_t r, output out_item_t res);
    u64 err, v;
    bit is_major;
    res = '0;
    if (r.read_present && r.base < 4 &&
        (r.base[1:0] == major_q || r.base[1:0] == minor_q)) begin
      is_major = (r.base[1:0] == major_q);
      err = phred_err(r.qscore);
      for (int k = 0; k < 3; k++) begin
        v = case_nll[k] + neg_ln_q(read_lik(is_major, k, err));
        case_nll[k] = (v > u64'(MAX40)) ? u64'(MAX40) : v;
      end
      indiv_hit = 1'b1;
      site_hit = 1'b1;
    end
    if (r.last_of_individual || r.last_of_site) begin
      if (indiv_hit) fold_indiv();
      case_nll = '{0, 0, 0};
      indiv_hit = 1'b0;
    end
    if (r.last_of_site) begin
      res.neg_loglike = site_nll[47:0];
      res.no_data = !site_hit;
      site_nll = 0;
      site_hit = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALT_FREQ: freq_q = u64'(val);
      CFG_ADMIX:    admix_q = u64'(val);
      CFG_MAJOR:    major_q = val[1:0];
      CFG_MINOR:    minor_q = val[1:0];
    endcase
  endtask

  // offer one request, hold until taken, then maybe leave a gap
  task automatic send_read(in_item_t r, bit typed, out_item_t want);
    out_item_t res;
    int gap, sel;
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (predict_site(r, res)) site_results.push_back(typed ? want : res);
    sel = $urandom_range(0, 99);
    if (sel < 60) gap = 0;
    else if (sel < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(20, 200);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (site_results.size() == 0);
    repeat (3000) @(posedge clk);
  endtask

  function automatic in_item_t mk(bit p, bit [2:0] b, bit [6:0] q, bit li, bit ls);
    in_item_t r;
    r.read_present = p;
    r.base = b;
    r.qscore = q;
    r.last_of_individual = li;
    r.last_of_site = ls;
    return r;
  endfunction

  function automatic void add_row(in_item_t r, bit typed, out_item_t want);
    row_t row;
    row.req = r;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (site_results.size() == 0) begin
        $display("%0t: unexpected result neg_loglike=%h no_data=%b",
                 $time, out_data.neg_loglike, out_data.no_data);
        errors++;
      end else begin
        want = site_results.pop_front();
        if (out_data.neg_loglike !== want.neg_loglike) begin
          $display("%0t: neg_loglike expected %h actual %h",
                   $time, want.neg_loglike, out_data.neg_loglike);
          errors++;
        end
        if (out_data.no_data !== want.no_data) begin
          $display("%0t: no_data expected %b actual %b",
                   $time, want.no_data, out_data.no_data);
          errors++;
        end
      end
    end
  end

  // receiver stalls; one long hold early on so the block backs up
  initial begin
    int sel, len;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen >= 2) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (60000) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      if (sel < 50) len = 0;
      else if (sel < 90) len = $urandom_range(1, 4);
      else len = $urandom_range(20, 400);
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    out_item_t none_out, zero_nd;
    in_item_t r;
    int phase_items;
    bit [2:0] b;
    none_out = '0;
    zero_nd.neg_loglike = '0;
    zero_nd.no_data = 1'b1;
    freq_q = 0; admix_q = 65536; major_q = 2'd0; minor_q = 2'd1;
    case_nll = '{0, 0, 0};
    site_nll = 0; indiv_hit = 1'b0; site_hit = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no-data sites, quality extremes, base cases, end flags
    add_row(mk(1'b0, 3'd6, 7'd127, 1'b0, 1'b1), 1'b1, zero_nd);
    add_row(mk(1'b1, 3'd4, 7'd127, 1'b1, 1'b1), 1'b1, zero_nd);
    add_row(mk(1'b1, 3'd2, 7'd0, 1'b0, 1'b1), 1'b1, zero_nd);
    add_row(mk(1'b1, 3'd0, 7'd0, 1'b0, 1'b0), 1'b0, none_out);
    add_row(mk(1'b1, 3'd1, 7'd93, 1'b1, 1'b0), 1'b0, none_out);
    add_row(mk(1'b1, 3'd0, 7'd127, 1'b1, 1'b0), 1'b0, none_out);
    add_row(mk(1'b0, 3'd0, 7'd30, 1'b1, 1'b0), 1'b0, none_out);
    add_row(mk(1'b1, 3'd7, 7'd5, 1'b0, 1'b0), 1'b0, none_out);
    add_row(mk(1'b1, 3'd3, 7'd40, 1'b0, 1'b1), 1'b0, none_out);
    add_row(mk(1'b1, 3'd1, 7'd1, 1'b1, 1'b1), 1'b0, none_out);
    add_row(mk(1'b1, 3'd5, 7'd64, 1'b0, 1'b0), 1'b0, none_out);
    add_row(mk(1'b1, 3'd1, 7'd94, 1'b0, 1'b1), 1'b0, none_out);
    foreach (dir_rows[i]) send_read(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    drain();

    // random phases under several register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(CFG_ALT_FREQ, 17'd0); write_reg(CFG_ADMIX, 17'd0); end
        1: begin write_reg(CFG_ALT_FREQ, 17'd65536); write_reg(CFG_ADMIX, 17'd65536); end
        2: begin write_reg(CFG_ALT_FREQ, 17'h1FFFF); write_reg(CFG_ADMIX, 17'h1FFFF); end
        3: begin write_reg(CFG_MAJOR, 17'd3); write_reg(CFG_MINOR, 17'd3); end
        4: begin write_reg(CFG_MAJOR, 17'd2); write_reg(CFG_MINOR, 17'd1); end
        default: begin
          write_reg(CFG_ALT_FREQ, 17'($urandom_range(0, 32'h1FFFF)));
          write_reg(CFG_ADMIX, 17'($urandom_range(0, 32'h1FFFF)));
          write_reg(CFG_MAJOR, 17'($urandom_range(0, 3)));
          write_reg(CFG_MINOR, 17'($urandom_range(0, 3)));
        end
      endcase
      phase_items = 0;
      while (phase_items < 125) begin
        if ($urandom_range(0, 99) < 75)
          b = $urandom_range(0, 1) ? {1'b0, major_q} : {1'b0, minor_q};
        else
          b = 3'($urandom_range(0, 7));
        r = mk($urandom_range(0, 9) != 0, b, 7'($urandom_range(0, 127)),
               $urandom_range(0, 5) == 0, $urandom_range(0, 23) == 0);
        if (r.last_of_individual && $urandom_range(0, 3) == 0) r.last_of_site = 1'b1;
        send_read(r, 1'b0, none_out);
        phase_items++;
      end
      r = mk(1'b1, {1'b0, major_q}, 7'($urandom_range(0, 127)), 1'b1, 1'b1);
      send_read(r, 1'b0, none_out);
      drain();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000000;
    $display("tb: errors");
    $finish;
  end

endmodule
